FILE: src/lzup_pkg.sv
// ----------------------------------------------------------------------------
// lzup_pkg
// Shared constants, types and the coefficient rom of the lanczos upsampler.
// ----------------------------------------------------------------------------
package lzup_pkg;

    localparam int UPSAMPLE_FACTOR = 2;
    localparam int LOBES           = 8;
    localparam int COEF_BITS       = 18;
    localparam int TAPS            = 2 * LOBES;
    localparam int FRAC_BITS       = COEF_BITS - 2;
    localparam int SAMPLE_W        = 24;
    localparam int ACC_W           = 48;
    localparam int PROD_W          = SAMPLE_W + COEF_BITS;
    localparam int TAP_W           = $clog2(TAPS);
    localparam int PHASE_W         = (UPSAMPLE_FACTOR > 1) ? $clog2(UPSAMPLE_FACTOR) : 1;
    localparam int CNT_W           = $clog2(LOBES + 1);
    localparam int ROM_DEPTH       = UPSAMPLE_FACTOR * TAPS;

    typedef logic signed [SAMPLE_W-1:0]  sample_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;

    // phase-major, tap 0 pairs with the newest history sample
    localparam coef_t COEF_ROM [ROM_DEPTH] = '{
        // phase 0
        18'sd0,     18'sd0,     18'sd0,     18'sd0,
        18'sd0,     18'sd0,     18'sd0,     18'sd0,
        18'sd65536, 18'sd0,     18'sd0,     18'sd0,
        18'sd0,     18'sd0,     18'sd0,     18'sd0,
        // phase 1
        -18'sd184,   18'sd699,   -18'sd1460,  18'sd2573,
        -18'sd4253,  18'sd7067,  -18'sd13117, 18'sd41454,
        18'sd41454,  -18'sd13117, 18'sd7067,  -18'sd4253,
        18'sd2573,   -18'sd1460,  18'sd699,   -18'sd184
    };

    typedef struct packed {
        logic push_in;
        logic push_zero;
        logic inc_fill;
        logic clr_hist;
        logic mac_step;
        logic phase_inc;
        logic phase_clr;
        logic load_out;
        logic out_run_end;
    } cmd_t;

    typedef struct packed {
        logic fill_full;
        logic tap_last;
        logic phase_last;
        logic out_free;
        logic flush_emit;
        logic flush_done;
    } sts_t;

endpackage

FILE: src/lzup_dp.sv
// ----------------------------------------------------------------------------
// lzup_dp
// Datapath: sample history, single mac over the taps, rounding and output reg.
// ----------------------------------------------------------------------------
module lzup_dp
    import lzup_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  sample_t in_sample,
    input  cmd_t    cmd,
    output sts_t    sts,
    output logic    out_valid,
    input  logic    out_ready,
    output sample_t out_sample,
    output logic    run_end
);

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam int Y_W = ACC_W - FRAC_BITS;
    localparam logic signed [Y_W-1:0] SAT_MAX = Y_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [Y_W-1:0] SAT_MIN = -Y_W'(1 << (SAMPLE_W - 1));

    sample_t                   hist_reg [TAPS];
    logic [CNT_W-1:0]          fill_reg;
    logic [CNT_W-1:0]          zc_reg;
    logic [TAP_W-1:0]          tap_reg;
    logic [PHASE_W-1:0]        phase_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      out_valid_reg;
    sample_t                   out_sample_reg;
    logic                      run_end_reg;

    logic [PHASE_W+TAP_W-1:0]  coef_idx;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   rnd;
    logic signed [Y_W-1:0]     y;
    sample_t                   sat;
    logic [CNT_W:0]            zc_fill_sum;

    assign coef_idx = {phase_reg, tap_reg};
    assign prod     = hist_reg[tap_reg] * COEF_ROM[coef_idx];
    assign acc_next = ((tap_reg == '0) ? '0 : acc_reg) + ACC_W'(prod);

    // round half up, then arithmetic shift down to q1.23
    assign rnd = acc_reg + RND_HALF;
    assign y   = rnd[ACC_W-1:FRAC_BITS];

    always_comb
    begin
        if (y > SAT_MAX)
        begin
            sat = SAMPLE_W'(SAT_MAX);
        end
        else if (y < SAT_MIN)
        begin
            sat = SAMPLE_W'(SAT_MIN);
        end
        else
        begin
            sat = y[SAMPLE_W-1:0];
        end
    end

    assign zc_fill_sum = {1'b0, zc_reg} + {1'b0, fill_reg};

    assign sts.fill_full  = (fill_reg == CNT_W'(LOBES));
    assign sts.tap_last   = (tap_reg == TAP_W'(TAPS - 1));
    assign sts.phase_last = (phase_reg == PHASE_W'(UPSAMPLE_FACTOR - 1));
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.flush_emit = (zc_fill_sum >= (CNT_W + 1)'(LOBES));
    assign sts.flush_done = (zc_reg == CNT_W'(LOBES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                hist_reg[i] <= '0;
            end
            fill_reg      <= '0;
            zc_reg        <= '0;
            tap_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_hist)
            begin
                for (int i = 0; i < TAPS; i++)
                begin
                    hist_reg[i] <= '0;
                end
            end
            else if (cmd.push_in || cmd.push_zero)
            begin
                for (int i = 1; i < TAPS; i++)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                hist_reg[0] <= cmd.push_in ? in_sample : '0;
            end

            if (cmd.clr_hist)
            begin
                fill_reg <= '0;
            end
            else if (cmd.inc_fill)
            begin
                fill_reg <= fill_reg + 1'b1;
            end

            if (cmd.clr_hist)
            begin
                zc_reg <= '0;
            end
            else if (cmd.push_zero)
            begin
                zc_reg <= zc_reg + 1'b1;
            end

            if (cmd.mac_step)
            begin
                tap_reg <= sts.tap_last ? '0 : tap_reg + 1'b1;
            end

            if (cmd.phase_clr)
            begin
                phase_reg <= '0;
            end
            else if (cmd.phase_inc)
            begin
                phase_reg <= phase_reg + 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_step)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.load_out)
        begin
            out_sample_reg <= sat;
            run_end_reg    <= cmd.out_run_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign run_end    = run_end_reg;

endmodule

FILE: src/lzup_ctrl.sv
// ----------------------------------------------------------------------------
// lzup_ctrl
// Controller: sequences input transfer, mac passes, output loads and flush.
// ----------------------------------------------------------------------------
module lzup_ctrl
    import lzup_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic is_last,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_OUT   = 2'd2;
    localparam logic [1:0] S_FPUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       last_reg;
    logic       last_next;
    logic       flushing_reg;
    logic       flushing_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        last_next     = last_reg;
        flushing_next = flushing_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.push_in = 1'b1;
                    last_next   = is_last;
                    if (sts.fill_full)
                    begin
                        state_next = S_MAC;
                    end
                    else
                    begin
                        cmd.inc_fill = 1'b1;
                        if (is_last)
                        begin
                            flushing_next = 1'b1;
                            state_next    = S_FPUSH;
                        end
                    end
                end
            end
            S_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (sts.tap_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out    = 1'b1;
                    cmd.out_run_end = sts.phase_last &&
                                      (flushing_reg ? sts.flush_done : !last_reg);
                    if (!sts.phase_last)
                    begin
                        cmd.phase_inc = 1'b1;
                        state_next    = S_MAC;
                    end
                    else
                    begin
                        cmd.phase_clr = 1'b1;
                        if (flushing_reg)
                        begin
                            if (sts.flush_done)
                            begin
                                cmd.clr_hist  = 1'b1;
                                flushing_next = 1'b0;
                                state_next    = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_FPUSH;
                            end
                        end
                        else if (last_reg)
                        begin
                            flushing_next = 1'b1;
                            state_next    = S_FPUSH;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_FPUSH:
            begin
                // zeros beyond the clip; the last held inputs each get an emit
                cmd.push_zero = 1'b1;
                if (sts.flush_emit)
                begin
                    state_next = S_MAC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            last_reg     <= 1'b0;
            flushing_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            last_reg     <= last_next;
            flushing_reg <= flushing_next;
        end
    end

endmodule

FILE: src/lanczos_integer_upsampler.sv
// sequence: an item taken with 8 inputs in the history runs one mac per tap,
//   16 taps for each of 2 phases, each pass followed by one output load that
//   waits while the output is stalled; input is not ready until the item is done;
//   the item marked last adds 8 zero pushes and up to 16 more results
// reset: asynchronous, clears history, counters, state and output valid
// ----------------------------------------------------------------------------
// lanczos_integer_upsampler
// Upsamples one audio channel by two with an 8-lobe lanczos kernel.
// ----------------------------------------------------------------------------
module lanczos_integer_upsampler
    import lzup_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  sample_t in_sample,
    input  logic    is_last,
    output logic    out_valid,
    input  logic    out_ready,
    output sample_t out_sample,
    output logic    run_end
);

    cmd_t cmd;
    sts_t sts;

    lzup_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .is_last  (is_last),
        .sts      (sts),
        .cmd      (cmd)
    );

    lzup_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_sample  (in_sample),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sample (out_sample),
        .run_end    (run_end)
    );

endmodule

FILE: src/lzup_checker.sv
// ----------------------------------------------------------------------------
// lzup_checker
// Port-level checks of the lanczos upsampler, bound to the top level.
// ----------------------------------------------------------------------------
module lzup_checker
    import lzup_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input sample_t in_sample,
    input logic    is_last,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t out_sample,
    input logic    run_end
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(run_end))
        else $error("output changed while stalled");

    // offered input holds until its transfer
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_sample) && $stable(is_last))
        else $error("input changed while waiting");

    // a clip end always starts a flush, so input is closed next cycle
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && is_last |=> !in_ready)
        else $error("input open right after last transfer");

    a_rst_out: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

    a_rst_in: assert property (@(posedge clk)
        !rst_n |-> in_ready)
        else $error("input not ready during reset");

endmodule

bind lanczos_integer_upsampler lzup_checker u_lzup_checker (.*);
